>>> hdl/mmw_pkg.sv
package mmw_pkg;

	localparam int PIX_W = 8;
	localparam int CFG_W = 11;
	localparam int ROW_W = 11;
	localparam int OFS_W = 4;

	localparam logic [1:0] REG_RADIUS = 2'd0;
	localparam logic [1:0] REG_MODE   = 2'd1;
	localparam logic [1:0] REG_WIDTH  = 2'd2;
	localparam logic [1:0] REG_HEIGHT = 2'd3;

	localparam logic [1:0] MODE_MEDIAN = 2'd0;
	localparam logic [1:0] MODE_MEAN   = 2'd1;
	localparam logic [1:0] MODE_BOTH   = 2'd2;
	localparam logic [1:0] MODE_ALIAS  = 2'd3;

	localparam logic FUNC_PIXEL = 1'b0;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_IN     = 9'b000000010,
		ST_MIDCHK = 9'b000000100,
		ST_OUTCHK = 9'b000001000,
		ST_GATHER = 9'b000010000,
		ST_DRAIN  = 9'b000100000,
		ST_DIV    = 9'b001000000,
		ST_MIDWR  = 9'b010000000,
		ST_EMIT   = 9'b100000000
	} state_t;

	typedef struct packed {
		logic clear;
		logic load;
	} chain_ctrl_t;

	// taps in a window of side 2r+1
	function automatic logic [5:0] taps_of(input logic [1:0] r);
		logic [5:0] s;
		s = {3'b000, r, 1'b1};
		return s * s;
	endfunction

endpackage

>>> hdl/mmw_ram.sv
module mmw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hdl/mmw_cell.sv
module mmw_cell import mmw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clear,
	input  logic             in_valid,
	input  logic [PIX_W-1:0] in_data,
	output logic             out_valid,
	output logic [PIX_W-1:0] out_data,
	output logic [PIX_W-1:0] value
);

	logic             full_q;
	logic [PIX_W-1:0] val_q;
	logic             pass_q;
	logic [PIX_W-1:0] pdata_q;

	// keep the smaller value, hand the larger one on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			pass_q <= 1'b0;
		end else if (clear) begin
			full_q <= 1'b0;
			pass_q <= 1'b0;
		end else if (in_valid) begin
			full_q <= 1'b1;
			pass_q <= full_q;
		end else begin
			pass_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			if (!full_q || in_data < val_q) begin
				val_q   <= in_data;
				pdata_q <= val_q;
			end else begin
				pdata_q <= in_data;
			end
		end
	end

	assign out_valid = pass_q;
	assign out_data  = pdata_q;
	assign value     = val_q;

endmodule

>>> hdl/mmw_chain.sv
module mmw_chain import mmw_pkg::*; #(
	parameter int NCELL = 49
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  chain_ctrl_t              ctrl,
	input  logic [PIX_W-1:0]         din,
	input  logic [$clog2(NCELL)-1:0] sel,
	output logic [PIX_W-1:0]         dout
);

	logic             v   [NCELL+1];
	logic [PIX_W-1:0] d   [NCELL+1];
	logic [PIX_W-1:0] val [NCELL];

	assign v[0] = ctrl.load;
	assign d[0] = din;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		mmw_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.clear    (ctrl.clear),
			.in_valid (v[i]),
			.in_data  (d[i]),
			.out_valid(v[i+1]),
			.out_data (d[i+1]),
			.value    (val[i])
		);
	end

	// cell i holds the i-th smallest once the chain has settled
	assign dout = val[sel];

endmodule

>>> hdl/median_mean_window_filter.sv
// A transaction that yields nothing passes ST_IDLE, ST_IN, ST_MIDCHK and ST_OUTCHK
// (a flush that is ignored only ST_IDLE and ST_IN). Each window pass reads the line store
// once per tap (N = (2R+1)^2 taps) into the sorting cell row; a mean adds the divider
// steps in ST_DIV, a mode-2 median the store in ST_MIDWR, and the output handoff ST_EMIT.
// Result latency follows the raster lag of R rows and R pixels (twice that in mode 2).
// arst_n resets FSM, positions, output valid, register defaults; line stores not cleared.
module median_mean_window_filter import mmw_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [7:0] pixel_in
	input  logic             s_tuser,   // [0] func
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,   // [7:0] pixel_out
	output logic             m_tlast,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_addr,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int WW    = XW + 1;
	localparam int LW    = XW + ROW_W + 1;
	localparam int RING  = 2 * MAX_RADIUS + 2;
	localparam int RB    = $clog2(RING);
	localparam int DEPTH = RING << XW;
	localparam int AW    = RB + XW;
	localparam int NCELL = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
	localparam int NB    = $clog2(NCELL + 2);
	localparam int SW    = NB + PIX_W;
	localparam int IW    = $clog2(NCELL);

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [XW-1:0]    col;
		logic [RB-1:0]    ring;
		logic [LW-1:0]    lin;
	} pos_t;

	function automatic pos_t pos_next(input pos_t p, input logic [WW-1:0] w);
		pos_t q;
		q     = p;
		q.lin = p.lin + 1'b1;
		if (WW'({1'b0, p.col}) + 1'b1 >= w) begin
			q.col = '0;
			q.row = p.row + 1'b1;
			q.ring = (p.ring == RB'(RING - 1)) ? '0 : p.ring + 1'b1;
		end else begin
			q.col = p.col + 1'b1;
		end
		return q;
	endfunction

	state_t state_q;

	logic [1:0]       radius_q, mode_q;
	logic [CFG_W-1:0] fw_q, fh_q;
	logic [1:0]       r_eff, mode_eff;
	logic [WW-1:0]    w_eff;
	logic [ROW_W-1:0] h_eff;
	logic [LW-1:0]    total_q, lag_q;
	logic [5:0]       n_taps;
	logic [NB-1:0]    n_eff;

	pos_t in_q, mid_q, out_q, c_q;

	logic             func_q;
	logic [PIX_W-1:0] pix_q;
	logic             is_mid_q, src_mean_q, do_mean_q;
	logic             rd_s1;
	logic [NB:0]      cnt_q;
	logic signed [OFS_W-1:0] dy_q, dx_q, r_neg;
	logic [SW-1:0]    sum_q, rem_q, dvs_q;
	logic [PIX_W-1:0] quo_q;
	logic [2:0]       dbit_q;

	logic             out_valid_q, out_last_q;
	logic [PIX_W-1:0] out_pix_q;

	logic [PIX_W-1:0] med_rdata, mean_rdata, tap;
	logic [PIX_W-1:0] med_val;
	logic [AW-1:0]    raddr;
	chain_ctrl_t      chain_ctrl;
	logic [IW-1:0]    med_sel;

	logic             mid_go, out_go, emit_ok;
	logic [LW-1:0]    avail;

	always_comb begin
		r_eff = (radius_q == 2'd0) ? 2'd1 :
			(32'(radius_q) > MAX_RADIUS) ? 2'(MAX_RADIUS) : radius_q;
		mode_eff = (mode_q == MODE_ALIAS) ? MODE_MEDIAN : mode_q;
		if (fw_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(fw_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(fw_q);
		end
		h_eff  = (fh_q == '0) ? ROW_W'(1) : fh_q;
		n_taps = taps_of(r_eff);
		n_eff  = NB'(n_taps);
		r_neg  = -$signed({2'b00, r_eff});
		med_sel = IW'((n_taps - 6'd1) >> 1);
	end

	// frame size and lag are registered from the config registers; an item accepted after a write sees the new values
	always_ff @(posedge clk) begin
		total_q <= LW'(w_eff) * LW'(h_eff);
		lag_q   <= LW'(w_eff) * LW'(r_eff) + LW'(r_eff);
	end

	assign avail  = (mode_eff == MODE_BOTH) ? mid_q.lin : in_q.lin;
	assign mid_go = (mode_eff == MODE_BOTH) && (mid_q.lin < total_q) &&
		((in_q.lin >= mid_q.lin + lag_q + 1'b1) || (in_q.lin == total_q));
	assign out_go = (out_q.lin < total_q) &&
		((avail >= out_q.lin + lag_q + 1'b1) || (avail == total_q));
	assign emit_ok = !out_valid_q || m_tready;

	// window address with edge replication
	always_comb begin
		logic signed [ROW_W+1:0] ys, ydel;
		logic signed [XW+1:0]    xs;
		logic signed [RB+1:0]    rs;
		ys = $signed({2'b00, c_q.row}) + (ROW_W+2)'(dy_q);
		if (ys < 0) begin
			ys = '0;
		end else if (ys > $signed({2'b00, h_eff}) - (ROW_W+2)'(1)) begin
			ys = $signed({2'b00, h_eff}) - (ROW_W+2)'(1);
		end
		ydel = ys - $signed({2'b00, c_q.row});
		rs = $signed({2'b00, c_q.ring}) + (RB+2)'(ydel);
		if (rs < 0) begin
			rs = rs + (RB+2)'(RING);
		end else if (rs >= (RB+2)'(RING)) begin
			rs = rs - (RB+2)'(RING);
		end
		xs = $signed({2'b00, c_q.col}) + (XW+2)'(dx_q);
		if (xs < 0) begin
			xs = '0;
		end else if (xs > $signed({1'b0, w_eff}) - (XW+2)'(1)) begin
			xs = $signed({1'b0, w_eff}) - (XW+2)'(1);
		end
		raddr = {rs[RB-1:0], xs[XW-1:0]};
	end

	mmw_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_med_ram (
		.clk  (clk),
		.we   (state_q == ST_IN && func_q == FUNC_PIXEL && in_q.lin < total_q),
		.waddr({in_q.ring, in_q.col}),
		.wdata(pix_q),
		.re   (state_q == ST_GATHER),
		.raddr(raddr),
		.rdata(med_rdata)
	);

	mmw_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_mean_ram (
		.clk  (clk),
		.we   (state_q == ST_MIDWR),
		.waddr({mid_q.ring, mid_q.col}),
		.wdata(med_val),
		.re   (state_q == ST_GATHER),
		.raddr(raddr),
		.rdata(mean_rdata)
	);

	assign tap = src_mean_q ? mean_rdata : med_rdata;
	assign chain_ctrl.clear = (state_q == ST_MIDCHK && mid_go) ||
		(state_q == ST_OUTCHK && out_go);
	assign chain_ctrl.load  = rd_s1;

	mmw_chain #(.NCELL(NCELL)) u_chain (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (chain_ctrl),
		.din   (tap),
		.sel   (med_sel),
		.dout  (med_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			radius_q    <= 2'd1;
			mode_q      <= MODE_MEDIAN;
			fw_q        <= CFG_W'(512);
			fh_q        <= CFG_W'(512);
			in_q        <= '0;
			mid_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			rd_s1       <= 1'b0;
		end else begin
			rd_s1 <= (state_q == ST_GATHER);
			if (!cfg_we && state_q == ST_EMIT && emit_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_addr)
					REG_RADIUS: radius_q <= cfg_wdata[1:0];
					REG_MODE:   mode_q   <= cfg_wdata[1:0];
					REG_WIDTH:  fw_q     <= cfg_wdata;
					REG_HEIGHT: fh_q     <= cfg_wdata;
					default:    radius_q <= radius_q;
				endcase
				in_q  <= '0;
				mid_q <= '0;
				out_q <= '0;
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (s_tvalid) begin
							state_q <= ST_IN;
						end
					end
					ST_IN: begin
						if (in_q.lin < total_q) begin
							if (func_q == FUNC_PIXEL) begin
								in_q    <= pos_next(in_q, w_eff);
								state_q <= ST_MIDCHK;
							end else begin
								state_q <= ST_IDLE;
							end
						end else begin
							state_q <= ST_MIDCHK;
						end
					end
					ST_MIDCHK: begin
						state_q <= mid_go ? ST_GATHER : ST_OUTCHK;
					end
					ST_OUTCHK: begin
						state_q <= out_go ? ST_GATHER : ST_IDLE;
					end
					ST_GATHER: begin
						if (cnt_q == (NB+1)'(n_eff - 1'b1)) begin
							state_q <= ST_DRAIN;
						end
					end
					ST_DRAIN: begin
						if (cnt_q == (NB+1)'(n_eff) + 1'b1) begin
							if (is_mid_q) begin
								state_q <= ST_MIDWR;
							end else if (do_mean_q) begin
								state_q <= ST_DIV;
							end else begin
								state_q <= ST_EMIT;
							end
						end
					end
					ST_DIV: begin
						if (dbit_q == 3'd0) begin
							state_q <= ST_EMIT;
						end
					end
					ST_MIDWR: begin
						mid_q   <= pos_next(mid_q, w_eff);
						state_q <= ST_OUTCHK;
					end
					ST_EMIT: begin
						if (emit_ok) begin
							if (out_q.lin + 1'b1 == total_q) begin
								in_q  <= '0;
								mid_q <= '0;
								out_q <= '0;
							end else begin
								out_q <= pos_next(out_q, w_eff);
							end
							state_q <= ST_IDLE;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			func_q <= s_tuser;
			pix_q  <= s_tdata;
		end
		if (state_q == ST_MIDCHK && mid_go) begin
			c_q        <= mid_q;
			is_mid_q   <= 1'b1;
			src_mean_q <= 1'b0;
			do_mean_q  <= 1'b0;
		end
		if (state_q == ST_OUTCHK && out_go) begin
			c_q        <= out_q;
			is_mid_q   <= 1'b0;
			src_mean_q <= (mode_eff == MODE_BOTH);
			do_mean_q  <= (mode_eff != MODE_MEDIAN);
		end
		if (chain_ctrl.clear) begin
			cnt_q <= '0;
			dy_q  <= r_neg;
			dx_q  <= r_neg;
			sum_q <= '0;
		end else if (state_q == ST_GATHER) begin
			if (cnt_q == (NB+1)'(n_eff - 1'b1)) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (dx_q == -r_neg) begin
				dx_q <= r_neg;
				dy_q <= dy_q + 1'b1;
			end else begin
				dx_q <= dx_q + 1'b1;
			end
		end else if (state_q == ST_DRAIN) begin
			cnt_q <= cnt_q + 1'b1;
		end
		if (rd_s1) begin
			sum_q <= sum_q + SW'(tap);
		end
		// restoring divide of the window sum by the tap count, one bit a cycle
		if (state_q == ST_DRAIN) begin
			rem_q  <= sum_q;
			dvs_q  <= SW'(n_eff) << (PIX_W - 1);
			dbit_q <= 3'd7;
		end else if (state_q == ST_DIV) begin
			if (rem_q >= dvs_q) begin
				rem_q <= rem_q - dvs_q;
				quo_q <= {quo_q[PIX_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[PIX_W-2:0], 1'b0};
			end
			dvs_q  <= dvs_q >> 1;
			dbit_q <= dbit_q - 1'b1;
		end
		if (state_q == ST_EMIT && emit_ok) begin
			out_pix_q  <= do_mean_q ? quo_q : med_val;
			out_last_q <= (out_q.lin + 1'b1 == total_q);
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_pix_q;
	assign m_tlast  = out_last_q;

endmodule

>>> hdl/mmw_checker.sv
module mmw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	// one transaction in flight: input side closes right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while previous transaction still in work");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("output valid during reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("output payload changed while stalled");

endmodule

bind median_mean_window_filter mmw_checker u_mmw_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);
